// ----- rtl/rsp_pkg.sv -----
// ----------------------------------------------------------------------------
// rsp_pkg
// Types and constants shared by the rectangle subtraction block.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned NUM_PIECES  = 4;
  localparam int unsigned IDX_WIDTH   = 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic [IDX_WIDTH-1:0]          pidx_t;

  typedef struct packed {
    coord_t l;
    coord_t t;
    coord_t r;
    coord_t b;
  } rect_t;

  typedef struct packed {
    coord_t src_left;
    coord_t src_top;
    coord_t src_right;
    coord_t src_bottom;
    coord_t cut_left;
    coord_t cut_top;
    coord_t cut_right;
    coord_t cut_bottom;
  } in_word_t;

  typedef struct packed {
    coord_t piece_left;
    coord_t piece_top;
    coord_t piece_right;
    coord_t piece_bottom;
    logic   piece_valid;
    pidx_t  piece_index;
    logic   last;
  } out_word_t;

endpackage

// ----- rtl/rect_subtract_pieces_unit.sv -----
// ----------------------------------------------------------------------------
// rect_subtract_pieces_unit
// Subtracts a cut rectangle from a source rectangle, giving up to four pieces.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) takes one word per
//   source/cut pair. Output channel (out_valid_o / out_stall_i / out_word_o)
//   gives one word per piece; last marks the final word of a pair. A pair
//   that leaves nothing gives one word with piece_valid clear.
//   Pipeline: input register, piece buffer (holding all pieces of one pair,
//   computed in a single pass), output register. The first piece of a pair
//   goes from the input register through the piece buffer to the output
//   register. Throughput: one output word per cycle while the output is not
//   stalled; a pair with n pieces (1 to 4) gives n words, and pairs giving
//   one word flow at one per cycle. The single output port sets the figure.
//   Reset clears all valid flags; no words are held afterwards.
//   A stalled output holds its word; the buffer and input register fill up
//   behind it and in_stall_o rises once the input register cannot move on.
// ----------------------------------------------------------------------------
module rect_subtract_pieces_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rsp_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rsp_pkg::out_word_t out_word_o
);

  // input register
  logic              in_vld_q;
  rsp_pkg::in_word_t in_q;

  // piece buffer
  logic                                 pb_vld_q;
  rsp_pkg::rect_t [rsp_pkg::NUM_PIECES-1:0] pb_rect_q, pb_rect_d;
  logic [rsp_pkg::NUM_PIECES-1:0]       pb_mask_q, pb_mask_d;
  logic                                 pb_pv_q, pb_pv_d;
  rsp_pkg::pidx_t                       pb_cnt_q;

  // output register
  logic               out_vld_q;
  rsp_pkg::out_word_t out_q, out_d;

  logic out_free, pb_pop, pb_last, pb_free, in_move, in_free;
  rsp_pkg::pidx_t                 sel;
  logic [rsp_pkg::NUM_PIECES-1:0] mask_rest;

  // normalised rectangles
  rsp_pkg::rect_t s, c;
  rsp_pkg::coord_t t1, b1;
  logic ovl;

  always_comb begin
    s.l = (in_q.src_left > in_q.src_right) ? in_q.src_right : in_q.src_left;
    s.r = (in_q.src_left > in_q.src_right) ? in_q.src_left  : in_q.src_right;
    s.t = (in_q.src_top > in_q.src_bottom) ? in_q.src_bottom : in_q.src_top;
    s.b = (in_q.src_top > in_q.src_bottom) ? in_q.src_top    : in_q.src_bottom;
    c.l = (in_q.cut_left > in_q.cut_right) ? in_q.cut_right : in_q.cut_left;
    c.r = (in_q.cut_left > in_q.cut_right) ? in_q.cut_left  : in_q.cut_right;
    c.t = (in_q.cut_top > in_q.cut_bottom) ? in_q.cut_bottom : in_q.cut_top;
    c.b = (in_q.cut_top > in_q.cut_bottom) ? in_q.cut_top    : in_q.cut_bottom;
  end

  assign ovl = (s.l <= c.r) && (c.l <= s.r) && (s.t <= c.b) && (c.t <= s.b);
  assign t1  = (c.t > s.t) ? c.t : s.t;
  assign b1  = (c.b < s.b) ? c.b : s.b;

  always_comb begin
    pb_rect_d = '0;
    pb_mask_d = '0;
    pb_pv_d   = 1'b1;
    if (!ovl) begin
      pb_rect_d[0] = s;
      pb_mask_d[0] = 1'b1;
    end else begin
      // band above the cut
      pb_rect_d[0] = '{l: s.l, t: s.t, r: s.r, b: c.t - rsp_pkg::coord_t'(1)};
      pb_mask_d[0] = c.t > s.t;
      // band below the cut
      pb_rect_d[1] = '{l: s.l, t: c.b + rsp_pkg::coord_t'(1), r: s.r, b: s.b};
      pb_mask_d[1] = c.b < s.b;
      // left strip
      pb_rect_d[2] = '{l: s.l, t: t1, r: c.l - rsp_pkg::coord_t'(1), b: b1};
      pb_mask_d[2] = c.l > s.l;
      // right strip
      pb_rect_d[3] = '{l: c.r + rsp_pkg::coord_t'(1), t: t1, r: s.r, b: b1};
      pb_mask_d[3] = c.r < s.r;
      if (pb_mask_d == '0) begin
        // cut covers source
        pb_rect_d    = '0;
        pb_mask_d[0] = 1'b1;
        pb_pv_d      = 1'b0;
      end
    end
  end

  // first remaining piece
  always_comb begin
    sel       = '0;
    mask_rest = pb_mask_q;
    if (pb_mask_q[0]) begin
      sel = rsp_pkg::pidx_t'(0);
    end else if (pb_mask_q[1]) begin
      sel = rsp_pkg::pidx_t'(1);
    end else if (pb_mask_q[2]) begin
      sel = rsp_pkg::pidx_t'(2);
    end else begin
      sel = rsp_pkg::pidx_t'(3);
    end
    mask_rest[sel] = 1'b0;
  end

  assign out_free   = !out_vld_q || !out_stall_i;
  assign pb_pop     = pb_vld_q && out_free;
  assign pb_last    = (mask_rest == '0);
  assign pb_free    = !pb_vld_q || (pb_pop && pb_last);
  assign in_move    = in_vld_q && pb_free;
  assign in_free    = !in_vld_q || in_move;
  assign in_stall_o = !in_free;

  always_comb begin
    out_d.piece_left   = pb_rect_q[sel].l;
    out_d.piece_top    = pb_rect_q[sel].t;
    out_d.piece_right  = pb_rect_q[sel].r;
    out_d.piece_bottom = pb_rect_q[sel].b;
    out_d.piece_valid  = pb_pv_q;
    out_d.piece_index  = pb_cnt_q;
    out_d.last         = pb_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pb_vld_q  <= 1'b0;
      pb_mask_q <= '0;
      pb_cnt_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_vld_q <= in_valid_i;
      end
      if (in_move) begin
        pb_vld_q  <= 1'b1;
        pb_mask_q <= pb_mask_d;
        pb_cnt_q  <= '0;
      end else if (pb_pop) begin
        pb_vld_q  <= !pb_last;
        pb_mask_q <= mask_rest;
        pb_cnt_q  <= pb_cnt_q + rsp_pkg::pidx_t'(1);
      end
      if (out_free) begin
        out_vld_q <= pb_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q <= in_word_i;
    end
    if (in_move) begin
      pb_rect_q <= pb_rect_d;
      pb_pv_q   <= pb_pv_d;
    end
    if (pb_pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_pb_mask_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pb_vld_q |-> (pb_mask_q != '0))
    else $error("piece buffer valid with no pieces left");

  a_pb_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pb_vld_q |-> ((int'(pb_cnt_q) + $countones(pb_mask_q)) <= 4))
    else $error("piece count exceeds four");

  a_empty_word_alone : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.piece_valid) |-> (out_q.last && out_q.piece_index == '0))
    else $error("empty result not alone");

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_stall_i && !out_q.last) |=>
      (out_vld_q && out_q.piece_index == $past(out_q.piece_index) + 2'd1))
    else $error("run of pieces broken");

endmodule

// ----- tb/rect_subtract_pieces_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_subtract_pieces_checker
// Watches both channels of the rectangle subtraction block. Each accepted
// source/cut pair is turned into the pieces it should leave. These are held
// in order, and every accepted output word is compared field by field with
// the oldest piece still waiting.
// ----------------------------------------------------------------------------
module rect_subtract_pieces_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  rsp_pkg::in_word_t  in_word_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  rsp_pkg::out_word_t out_word_i,
  output int                 mismatches_o,
  output int                 waiting_o,
  output int                 pairs_o,
  output int                 words_o,
  output int                 empties_o,
  output int                 four_piece_o
);

  rsp_pkg::out_word_t waiting_pieces[$];
  int        mismatch_count  = 0;
  int        pair_count      = 0;
  int        word_count      = 0;
  int        empty_count     = 0;
  int        four_piece_count = 0;

  function automatic rsp_pkg::out_word_t make_piece(rsp_pkg::coord_t l, rsp_pkg::coord_t t,
                                                    rsp_pkg::coord_t r, rsp_pkg::coord_t b,
                                                    logic valid, int idx);
    rsp_pkg::out_word_t p;
    p.piece_left   = l;
    p.piece_top    = t;
    p.piece_right  = r;
    p.piece_bottom = b;
    p.piece_valid  = valid;
    p.piece_index  = rsp_pkg::pidx_t'(idx);
    p.last         = 1'b0;
    return p;
  endfunction

  // Source minus cut, both normalised first; pieces go out above, below,
  // then left and right strips within the cut's rows.
  function automatic void cut_pieces(rsp_pkg::in_word_t w);
    rsp_pkg::coord_t    sl, st, sr, sb, cl, ct, cr, cb, tmp;
    rsp_pkg::out_word_t found[4];
    int                 n;
    n  = 0;
    sl = w.src_left;  st = w.src_top;  sr = w.src_right;  sb = w.src_bottom;
    cl = w.cut_left;  ct = w.cut_top;  cr = w.cut_right;  cb = w.cut_bottom;
    if (sl > sr) begin tmp = sl; sl = sr; sr = tmp; end
    if (st > sb) begin tmp = st; st = sb; sb = tmp; end
    if (cl > cr) begin tmp = cl; cl = cr; cr = tmp; end
    if (ct > cb) begin tmp = ct; ct = cb; cb = tmp; end
    if (cl > sr || cr < sl || ct > sb || cb < st) begin
      found[0] = make_piece(sl, st, sr, sb, 1'b1, 0);
      n = 1;
    end else begin
      if (ct > st) begin
        found[n] = make_piece(sl, st, sr, ct - rsp_pkg::coord_t'(1), 1'b1, n);
        n++;
        st = ct;
      end
      if (cb < sb) begin
        found[n] = make_piece(sl, cb + rsp_pkg::coord_t'(1), sr, sb, 1'b1, n);
        n++;
        sb = cb;
      end
      if (cl > sl) begin
        found[n] = make_piece(sl, st, cl - rsp_pkg::coord_t'(1), sb, 1'b1, n);
        n++;
      end
      if (cr < sr) begin
        found[n] = make_piece(cr + rsp_pkg::coord_t'(1), st, sr, sb, 1'b1, n);
        n++;
      end
      if (n == 0) begin
        found[0] = make_piece('0, '0, '0, '0, 1'b0, 0);
        n = 1;
        empty_count++;
      end
    end
    if (n == 4) four_piece_count++;
    found[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) waiting_pieces.push_back(found[i]);
  endfunction

  function automatic void report_field(string field, longint expected, longint actual);
    if (expected != actual) begin
      $display("%0t: %s expected %0d, got %0d", $time, field, expected, actual);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    rsp_pkg::out_word_t exp_word;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_i) begin
        cut_pieces(in_word_i);
        pair_count++;
      end
      if (out_valid_i && !out_stall_i) begin
        word_count++;
        if (waiting_pieces.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %p", $time, out_word_i);
          mismatch_count++;
        end else begin
          exp_word = waiting_pieces.pop_front();
          report_field("piece_left",   exp_word.piece_left,   out_word_i.piece_left);
          report_field("piece_top",    exp_word.piece_top,    out_word_i.piece_top);
          report_field("piece_right",  exp_word.piece_right,  out_word_i.piece_right);
          report_field("piece_bottom", exp_word.piece_bottom, out_word_i.piece_bottom);
          report_field("piece_valid",  exp_word.piece_valid,  out_word_i.piece_valid);
          report_field("piece_index",  exp_word.piece_index,  out_word_i.piece_index);
          report_field("last",         exp_word.last,         out_word_i.last);
        end
      end
    end
    mismatches_o <= mismatch_count;
    waiting_o    <= waiting_pieces.size();
    pairs_o      <= pair_count;
    words_o      <= word_count;
    empties_o    <= empty_count;
    four_piece_o <= four_piece_count;
  end

endmodule

// ----- tb/rect_subtract_pieces_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_subtract_pieces_unit_tb
// Drives source/cut pairs into the rectangle subtraction block: a directed
// set of corner cases, then random pairs mostly clustered so that they
// overlap. The input idles and the output stalls at random; a checker beside the block
// predicts and compares every piece.
// ----------------------------------------------------------------------------
module rect_subtract_pieces_unit_tb;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  rsp_pkg::in_word_t  in_word;
  logic               out_valid;
  logic               out_stall;
  rsp_pkg::out_word_t out_word;

  int mismatches, waiting, pairs, words, empties, four_piece;

  always #4 clk = ~clk;

  rect_subtract_pieces_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_word_o  (out_word)
  );

  rect_subtract_pieces_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_word_i    (in_word),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_word_i   (out_word),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .pairs_o      (pairs),
    .words_o      (words),
    .empties_o    (empties),
    .four_piece_o (four_piece)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic rsp_pkg::in_word_t pair_of(int sl, int st, int sr, int sb,
                                                int cl, int ct, int cr, int cb);
    rsp_pkg::in_word_t w;
    w.src_left = rsp_pkg::coord_t'(sl);  w.src_top = rsp_pkg::coord_t'(st);
    w.src_right = rsp_pkg::coord_t'(sr); w.src_bottom = rsp_pkg::coord_t'(sb);
    w.cut_left = rsp_pkg::coord_t'(cl);  w.cut_top = rsp_pkg::coord_t'(ct);
    w.cut_right = rsp_pkg::coord_t'(cr); w.cut_bottom = rsp_pkg::coord_t'(cb);
    return w;
  endfunction

  function automatic int near_coord(int base);
    return base + int'($urandom_range(0, 40));
  endfunction

  // Mostly pairs clustered in a small window so they overlap; some cut
  // covering the source, some wholly random words.
  function automatic rsp_pkg::in_word_t random_pair();
    rsp_pkg::in_word_t w;
    rsp_pkg::coord_t   tmp;
    int                pick, base, x0, y0, x1, y1;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      w = rsp_pkg::in_word_t'({$urandom(), $urandom(), $urandom(), $urandom()});
    end else if (pick < 32) begin
      base = int'($urandom_range(0, 64000)) - 32000;
      x0 = base + int'($urandom_range(0, 20));
      y0 = base + int'($urandom_range(0, 20));
      x1 = x0 + int'($urandom_range(0, 20));
      y1 = y0 + int'($urandom_range(0, 20));
      w = pair_of(x0, y0, x1, y1,
                  x0 - int'($urandom_range(0, 2)), y0 - int'($urandom_range(0, 2)),
                  x1 + int'($urandom_range(0, 2)), y1 + int'($urandom_range(0, 2)));
      if ($urandom_range(0, 1)) begin
        tmp = w.src_left; w.src_left = w.src_right; w.src_right = tmp;
      end
      if ($urandom_range(0, 1)) begin
        tmp = w.cut_top; w.cut_top = w.cut_bottom; w.cut_bottom = tmp;
      end
    end else begin
      x0 = $urandom_range(0, 99);
      if (x0 < 15)      base = -32768;
      else if (x0 < 30) base = 32767 - 40;
      else              base = int'($urandom_range(0, 64000)) - 32000;
      w = pair_of(near_coord(base), near_coord(base), near_coord(base), near_coord(base),
                  near_coord(base), near_coord(base), near_coord(base), near_coord(base));
    end
    return w;
  endfunction

  task automatic send_pair(rsp_pkg::in_word_t w, int gap);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Output stall: random bursts, with the odd long stretch left free.
  initial begin
    int stall_len, free_len;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      stall_len = pick_gap();
      free_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 100)
                                              : $urandom_range(1, 6);
      if (stall_len > 0) begin
        out_stall <= 1'b1;
        repeat (stall_len) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat (free_len - 1) @(posedge clk);
    end
  end

  initial begin
    #2000000;
    $display("rect_subtract_pieces_unit regression: fail");
    $finish;
  end

  initial begin
    in_valid = 1'b0;
    in_word  = '0;
    rst_n    = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair(pair_of(0, 0, 10, 10, 20, 20, 30, 30), pick_gap());       // apart
    send_pair(pair_of(5, 5, 10, 10, 0, 0, 20, 20), pick_gap());         // covered
    send_pair(pair_of(3, 3, 7, 7, 3, 3, 7, 7), pick_gap());             // identical
    send_pair(pair_of(0, 0, 100, 100, 10, 10, 20, 20), pick_gap());     // four pieces
    send_pair(pair_of(0, 0, 10, 10, 10, -5, 20, 20), pick_gap());       // shared column
    send_pair(pair_of(0, 0, 10, 10, -5, 10, 20, 30), pick_gap());       // shared row
    send_pair(pair_of(0, 0, 10, 10, 11, 0, 20, 10), pick_gap());        // adjacent
    send_pair(pair_of(100, 100, 0, 0, 10, 10, 20, 20), pick_gap());     // reversed src
    send_pair(pair_of(0, 0, 100, 100, 20, 20, 10, 10), pick_gap());     // reversed cut
    send_pair(pair_of(-32768, -32768, 32767, 32767, 0, 0, 0, 0), pick_gap());
    send_pair(pair_of(-32768, -32768, 32767, 32767,
                      32767, 32767, -32768, -32768), pick_gap());
    send_pair(pair_of(-32768, -32768, 32767, 32767,
                      -32768, -32768, -32768, -32768), pick_gap());
    send_pair(pair_of(32767, 32767, -32768, -32768,
                      32767, 32767, 32767, 32767), pick_gap());
    send_pair(pair_of(-100, -50, -10, -5, -60, -70, -40, -20), pick_gap());
    send_pair(pair_of(9, 9, 9, 9, 9, 9, 9, 9), pick_gap());
    send_pair(pair_of(9, 9, 9, 9, 8, 8, 8, 8), pick_gap());
    send_pair(pair_of(32767, 32767, 32767, 32767, -1, -1, -1, -1), pick_gap());
    send_pair(pair_of(0, 0, 10, 10, -5, 5, 20, 20), pick_gap());        // band above
    send_pair(pair_of(0, 0, 10, 10, -5, -5, 20, 5), pick_gap());        // band below
    send_pair(pair_of(0, 0, 10, 10, 5, -5, 20, 20), pick_gap());        // left strip
    send_pair(pair_of(0, 0, 10, 10, -5, -5, 5, 20), pick_gap());        // right strip
    send_pair(pair_of(0, 0, 10, 10, -5, 3, 20, 6), pick_gap());         // above and below

    for (int i = 0; i < 98; i++) begin
      if (i == 60) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
      end
      send_pair(random_pair(), (i >= 20 && i < 40) ? 0 : pick_gap());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Covered %0d pairs, %0d words checked: %0d empty results, %0d four-piece pairs.",
             pairs, words, empties, four_piece);
    if (mismatches == 0 && waiting == 0) begin
      $display("rect_subtract_pieces_unit regression: pass");
    end else begin
      $display("rect_subtract_pieces_unit regression: fail");
    end
    $finish;
  end

endmodule
